/* design/dtt_pkg.sv */
// Shared types and constants for the deadline timer table.
package dtt_pkg;

  localparam int MAX_RESULTS = 16;

  localparam logic [2:0] ACT_ADD     = 3'd0;
  localparam logic [2:0] ACT_CANCEL  = 3'd1;
  localparam logic [2:0] ACT_REFRESH = 3'd2;
  localparam logic [2:0] ACT_RESET   = 3'd3;
  localparam logic [2:0] ACT_TICK    = 3'd4;
  localparam logic [2:0] ACT_QUERY   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INACTIVE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [7:0] CFG_IDLE_WAIT = 8'd0;
  localparam logic [7:0] CFG_ROLLOVER  = 8'd1;

  localparam logic [31:0] IDLE_WAIT_RST = 32'd1000;
  localparam logic [31:0] ROLLOVER_RST  = 32'd3600000;

  // result kinds loaded into the output register
  localparam logic [2:0] K_ZERO   = 3'd0;
  localparam logic [2:0] K_ADD    = 3'd1;
  localparam logic [2:0] K_FULL   = 3'd2;
  localparam logic [2:0] K_ID_OK  = 3'd3;
  localparam logic [2:0] K_ID_BAD = 3'd4;
  localparam logic [2:0] K_EXP    = 3'd5;
  localparam logic [2:0] K_QUERY  = 3'd6;

  // read address sources
  localparam logic [1:0] RS_SCAN = 2'd0;
  localparam logic [1:0] RS_ID   = 2'd1;
  localparam logic [1:0] RS_BEST = 2'd2;

  typedef struct packed {
    logic       latch;
    logic       emit;
    logic [2:0] kind;
    logic [1:0] rd_sel;
    logic       scan_start;
    logic       scan_run;
    logic       scan_min;
    logic       pend_load;
    logic       do_add;
    logic       do_cancel;
    logic       refr_wr;
    logic       rs_start;
    logic       rs_wr;
    logic       tick_init;
    logic       rearm;
  } dtt_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       out_free;
    logic       id_ok;
    logic       slot_act;
    logic       free_avail;
    logic       any_active;
    logic       scan_done;
    logic       pend_none;
    logic       rs_same;
    logic       exp_last;
  } dtt_sts_t;

endpackage

/* design/dtt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dtt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/dtt_ctrl.sv */
// Control state machine for the deadline timer table.
module dtt_ctrl
  import dtt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dtt_sts_t sts,
  output dtt_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_REFR   = 4'd2;
  localparam logic [3:0] S_RS_CHK = 4'd3;
  localparam logic [3:0] S_RS_WR  = 4'd4;
  localparam logic [3:0] S_PEND   = 4'd5;
  localparam logic [3:0] S_MIN    = 4'd6;
  localparam logic [3:0] S_BEST   = 4'd7;
  localparam logic [3:0] S_REARM  = 4'd8;
  localparam logic [3:0] S_QEMIT  = 4'd9;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.kind = K_ZERO;
    cmd.rd_sel = RS_SCAN;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.latch = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.action)
          ACT_ADD: begin
            if (sts.out_free) begin
              cmd.emit = 1'b1;
              cmd.kind = sts.free_avail ? K_ADD : K_FULL;
              cmd.do_add = sts.free_avail;
              state_next = S_IDLE;
            end
          end
          ACT_CANCEL: begin
            if (sts.out_free) begin
              cmd.emit = 1'b1;
              cmd.kind = sts.slot_act ? K_ID_OK : K_ID_BAD;
              cmd.do_cancel = sts.slot_act;
              state_next = S_IDLE;
            end
          end
          ACT_REFRESH: begin
            cmd.rd_sel = RS_ID;
            if (sts.slot_act) begin
              state_next = S_REFR;
            end else if (sts.out_free) begin
              cmd.emit = 1'b1;
              cmd.kind = K_ID_BAD;
              state_next = S_IDLE;
            end
          end
          ACT_RESET: begin
            cmd.rd_sel = RS_ID;
            if (sts.id_ok) begin
              state_next = S_RS_CHK;
            end else if (sts.out_free) begin
              cmd.emit = 1'b1;
              cmd.kind = K_ID_BAD;
              state_next = S_IDLE;
            end
          end
          ACT_TICK: begin
            if (sts.any_active) begin
              cmd.tick_init = 1'b1;
              cmd.scan_start = 1'b1;
              state_next = S_PEND;
            end else if (sts.out_free) begin
              cmd.emit = 1'b1;
              state_next = S_IDLE;
            end
          end
          ACT_QUERY: begin
            cmd.pend_load = 1'b1;
            cmd.scan_start = 1'b1;
            state_next = S_MIN;
          end
          default: begin
            if (sts.out_free) begin
              cmd.emit = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_REFR: begin
        cmd.rd_sel = RS_ID;
        if (sts.out_free) begin
          cmd.refr_wr = 1'b1;
          cmd.emit = 1'b1;
          cmd.kind = K_ID_OK;
          state_next = S_IDLE;
        end
      end
      S_RS_CHK: begin
        cmd.rd_sel = RS_ID;
        if (sts.rs_same || !sts.slot_act) begin
          if (sts.out_free) begin
            cmd.emit = 1'b1;
            cmd.kind = sts.rs_same ? K_ID_OK : K_ID_BAD;
            state_next = S_IDLE;
          end
        end else begin
          cmd.rs_start = 1'b1;
          state_next = S_RS_WR;
        end
      end
      S_RS_WR: begin
        cmd.rd_sel = RS_ID;
        if (sts.out_free) begin
          cmd.rs_wr = 1'b1;
          cmd.emit = 1'b1;
          cmd.kind = K_ID_OK;
          state_next = S_IDLE;
        end
      end
      S_PEND: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          if (!sts.pend_none) begin
            cmd.scan_start = 1'b1;
            state_next = S_MIN;
          end else if (sts.out_free) begin
            cmd.emit = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_MIN: begin
        cmd.scan_run = 1'b1;
        cmd.scan_min = 1'b1;
        if (sts.scan_done) begin
          state_next = (sts.action == ACT_QUERY) ? S_QEMIT : S_BEST;
        end
      end
      S_BEST: begin
        cmd.rd_sel = RS_BEST;
        state_next = S_REARM;
      end
      S_REARM: begin
        cmd.rd_sel = RS_BEST;
        if (sts.out_free) begin
          cmd.rearm = 1'b1;
          cmd.emit = 1'b1;
          cmd.kind = K_EXP;
          if (sts.exp_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            state_next = S_MIN;
          end
        end
      end
      S_QEMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = K_QUERY;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/dtt_dp.sv */
// Datapath: slot flags, slot memories, scan unit, config and output register.
module dtt_dp
  import dtt_pkg::*;
#(
  parameter int TIMER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  dtt_cmd_t    cmd,
  output dtt_sts_t    sts,
  input  logic [87:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        cfg_valid,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,
  output logic        m_tlast
);

  localparam int IW = $clog2(TIMER_SLOTS);
  localparam int CW = $clog2(TIMER_SLOTS + 1);

  logic [2:0]  act_q;
  logic [3:0]  id_q;
  logic [31:0] per_q;
  logic        rec_q;
  logic        fn_q;
  logic [47:0] now_q;

  logic [TIMER_SLOTS-1:0] active;
  logic [TIMER_SLOTS-1:0] recurring;
  logic [TIMER_SLOTS-1:0] pend;
  logic [47:0] prev_time;
  logic [31:0] idle_wait;
  logic [31:0] window;
  logic        roll;
  logic [4:0]  n_res;
  logic [47:0] start_q;

  logic [CW-1:0] scan_cnt;
  logic          rd_vld;
  logic [IW-1:0] rd_idx;
  logic          found;
  logic [IW-1:0] best;
  logic [47:0]   best_dl;

  logic [1:0]  o_status;
  logic [3:0]  o_id;
  logic        o_exp;
  logic [47:0] o_wait;

  logic [IW-1:0] id_idx;
  logic          id_valid;
  logic [IW-1:0] free_idx;
  logic          free_avail;
  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  logic [31:0]   per_rd;
  logic [47:0]   dl_rd;
  logic          per_we;
  logic          dl_we;
  logic [47:0]   sum_a;
  logic [31:0]   sum_b;
  logic [47:0]   sum;
  logic [TIMER_SLOTS-1:0] best_oh;
  logic          scan_issue;
  logic          exp_last;
  logic [47:0]   q_wait;
  logic          roll_now;

  assign id_idx   = IW'(id_q);
  assign id_valid = ({28'd0, id_q} < 32'(TIMER_SLOTS));

  always_comb begin
    free_idx = '0;
    free_avail = 1'b0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_idx = IW'(i);
        free_avail = 1'b1;
      end
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RS_ID:   raddr = id_idx;
      RS_BEST: raddr = best;
      default: raddr = scan_cnt[IW-1:0];
    endcase
  end

  assign sum_a = cmd.rs_wr ? start_q : now_q;
  assign sum_b = (cmd.do_add || cmd.rs_wr) ? per_q : per_rd;
  assign sum   = sum_a + {16'd0, sum_b};

  assign per_we = cmd.do_add || cmd.rs_wr;
  assign dl_we  = cmd.do_add || cmd.refr_wr || cmd.rs_wr || (cmd.rearm && recurring[best]);
  assign waddr  = cmd.do_add ? free_idx : (cmd.rearm ? best : id_idx);

  dtt_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_per_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (waddr),
    .wdata (per_q),
    .raddr (raddr),
    .rdata (per_rd)
  );

  dtt_ram #(.WIDTH(48), .DEPTH(TIMER_SLOTS)) u_dl_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (waddr),
    .wdata (sum),
    .raddr (raddr),
    .rdata (dl_rd)
  );

  assign best_oh    = TIMER_SLOTS'(1) << best;
  assign exp_last   = ((pend & ~best_oh) == '0) || (n_res == 5'(MAX_RESULTS - 1));
  assign scan_issue = (scan_cnt < CW'(TIMER_SLOTS));
  assign q_wait     = !found ? {16'd0, idle_wait} :
                      (now_q >= best_dl) ? 48'd0 : (best_dl - now_q);
  assign roll_now   = (now_q < prev_time) && ((prev_time - now_q) > {16'd0, window});

  always_comb begin
    sts.action     = act_q;
    sts.out_free   = !m_tvalid || m_tready;
    sts.id_ok      = id_valid;
    sts.slot_act   = id_valid && active[id_idx];
    sts.free_avail = free_avail;
    sts.any_active = (active != '0);
    sts.scan_done  = !scan_issue && !rd_vld;
    sts.pend_none  = (pend == '0);
    sts.rs_same    = (per_q == per_rd) && !fn_q;
    sts.exp_last   = exp_last;
  end

  // item and scratch registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_q <= s_tuser;
      id_q  <= s_tdata[3:0];
      per_q <= s_tdata[35:4];
      rec_q <= s_tdata[36];
      fn_q  <= s_tdata[37];
      now_q <= s_tdata[85:38];
    end
    if (cmd.rs_start) begin
      start_q <= fn_q ? now_q : (dl_rd - {16'd0, per_rd});
    end
    if (cmd.tick_init) begin
      roll <= roll_now;
    end
    if (cmd.scan_start) begin
      scan_cnt <= '0;
    end else if (cmd.scan_run && scan_issue) begin
      scan_cnt <= scan_cnt + CW'(1);
    end
    if (!cmd.scan_start && cmd.scan_run && scan_issue) begin
      rd_idx <= scan_cnt[IW-1:0];
    end
    if (cmd.scan_run && !cmd.scan_start && rd_vld && cmd.scan_min && pend[rd_idx] &&
        (!found || dl_rd < best_dl)) begin
      best    <= rd_idx;
      best_dl <= dl_rd;
    end
    if (cmd.emit) begin
      case (cmd.kind)
        K_ADD: begin
          o_status <= ST_OK;
          o_id     <= 4'(free_idx);
          o_exp    <= 1'b0;
          o_wait   <= '0;
          m_tlast  <= 1'b1;
        end
        K_FULL: begin
          o_status <= ST_FULL;
          o_id     <= '0;
          o_exp    <= 1'b0;
          o_wait   <= '0;
          m_tlast  <= 1'b1;
        end
        K_ID_OK: begin
          o_status <= ST_OK;
          o_id     <= id_q;
          o_exp    <= 1'b0;
          o_wait   <= '0;
          m_tlast  <= 1'b1;
        end
        K_ID_BAD: begin
          o_status <= ST_INACTIVE;
          o_id     <= id_q;
          o_exp    <= 1'b0;
          o_wait   <= '0;
          m_tlast  <= 1'b1;
        end
        K_EXP: begin
          o_status <= ST_OK;
          o_id     <= 4'(best);
          o_exp    <= 1'b1;
          o_wait   <= '0;
          m_tlast  <= exp_last;
        end
        K_QUERY: begin
          o_status <= ST_OK;
          o_id     <= '0;
          o_exp    <= 1'b0;
          o_wait   <= q_wait;
          m_tlast  <= 1'b1;
        end
        default: begin
          o_status <= ST_OK;
          o_id     <= '0;
          o_exp    <= 1'b0;
          o_wait   <= '0;
          m_tlast  <= 1'b1;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= '0;
      recurring <= '0;
      pend      <= '0;
      prev_time <= '0;
      idle_wait <= IDLE_WAIT_RST;
      window    <= ROLLOVER_RST;
      n_res     <= '0;
      rd_vld    <= 1'b0;
      found     <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_IDLE_WAIT) begin
          idle_wait <= cfg_data;
        end else if (cfg_index == CFG_ROLLOVER) begin
          window <= cfg_data;
        end
      end
      if (cmd.do_add) begin
        active[free_idx]    <= 1'b1;
        recurring[free_idx] <= rec_q;
      end
      if (cmd.do_cancel) begin
        active[id_idx] <= 1'b0;
      end
      if (cmd.tick_init) begin
        prev_time <= now_q;
        n_res     <= '0;
      end
      if (cmd.scan_start) begin
        rd_vld <= 1'b0;
        found  <= 1'b0;
      end else if (cmd.scan_run) begin
        rd_vld <= scan_issue;
        if (rd_vld) begin
          if (!cmd.scan_min) begin
            pend[rd_idx] <= active[rd_idx] && (roll || dl_rd <= now_q);
          end else if (pend[rd_idx] && (!found || dl_rd < best_dl)) begin
            found <= 1'b1;
          end
        end
      end
      if (cmd.pend_load) begin
        pend <= active;
      end
      if (cmd.rearm) begin
        pend[best] <= 1'b0;
        n_res      <= n_res + 5'd1;
        if (!recurring[best]) begin
          active[best] <= 1'b0;
        end
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {1'b0, o_wait, o_exp, o_id, o_status};

endmodule

/* design/deadline_timer_table_unit.sv */
// Deadline timer table: top level joining controller and datapath.
// Add, cancel, unknown actions and refresh of an inactive slot finish in dispatch;
// refresh adds a write state; reset adds a check state and a write state, skipping
// the write when the period is unchanged or the slot is inactive.
// Query runs one deadline scan, one slot per cycle; tick runs a pending scan, then
// one scan per result. Results wait while the output beat is held off. One item
// at a time; the output register lets the next item in while a result waits.
// Synchronous active-high rst clears flags, time, config and handshake state.
module deadline_timer_table_unit
  import dtt_pkg::*;
#(
  parameter int TIMER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // timer_id[3:0], period_ms[35:4], recurring[36], start_now[37], now_ms[85:38]
  input  logic [87:0] s_tdata,
  // action[2:0]
  input  logic [2:0]  s_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], timer_id_res[5:2], expired[6], next_wait[54:7]
  output logic [55:0] m_tdata,
  output logic        m_tlast
);

  dtt_cmd_t cmd;
  dtt_sts_t sts;

  assign cfg_ready = 1'b1;

  dtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dtt_dp #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

/* sim/dtt_checker.sv */
// Checker for the deadline timer table: watches the streams, predicts results, compares.
`timescale 1ns / 100ps
module dtt_checker
  import dtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [87:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending_results,
  output int          results_seen,
  output int          expiries_seen
);

  localparam int SLOTS = 16;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  id;
    logic        expired;
    logic [47:0] wait_ms;
    logic        last;
  } timer_result_t;

  logic        act   [SLOTS];
  logic        rec   [SLOTS];
  logic [31:0] per   [SLOTS];
  logic [47:0] dl    [SLOTS];
  logic [47:0] prev_time;
  logic [31:0] idle_wait, roll_window;
  timer_result_t expected_q[$];

  assign pending_results = expected_q.size();

  function automatic timer_result_t mk(logic [1:0] st, logic [3:0] id, logic ex,
                                       logic [47:0] w, logic l);
    timer_result_t r;
    r.status = st; r.id = id; r.expired = ex; r.wait_ms = w; r.last = l;
    return r;
  endfunction

  function automatic void add_exp(timer_result_t r);
    expected_q = {expected_q, r};
  endfunction

  task automatic tick_table(input logic [47:0] now);
    logic pend[SLOTS];
    logic any, roll;
    int n, best;
    any = 0; n = 0;
    for (int i = 0; i < SLOTS; i++) if (act[i]) any = 1;
    if (!any) begin
      add_exp(mk(ST_OK, 0, 0, 0, 1));
      return;
    end
    roll = (now < prev_time) && ((prev_time - now) > {16'd0, roll_window});
    prev_time = now;
    for (int i = 0; i < SLOTS; i++) pend[i] = act[i] && (roll || dl[i] <= now);
    while (n < MAX_RESULTS) begin
      best = -1;
      for (int i = 0; i < SLOTS; i++)
        if (pend[i] && (best < 0 || dl[i] < dl[best])) best = i;
      if (best < 0) break;
      pend[best] = 0;
      if (rec[best]) dl[best] = now + {16'd0, per[best]};
      else act[best] = 0;
      add_exp(mk(ST_OK, best[3:0], 1, 0, 0));
      n++;
    end
    if (n == 0) add_exp(mk(ST_OK, 0, 0, 0, 1));
    else expected_q[$].last = 1;
  endtask

  task automatic predict_item(input logic [2:0] a, input logic [87:0] d);
    logic [3:0]  id;
    logic [31:0] p;
    logic [47:0] now, start, w;
    logic        r, fn, found;
    int best;
    id = d[3:0]; p = d[35:4]; r = d[36]; fn = d[37]; now = d[85:38];
    found = 0;
    case (a)
      ACT_ADD: begin
        for (int i = 0; i < SLOTS; i++)
          if (!found && !act[i]) begin
            found = 1; act[i] = 1; rec[i] = r; per[i] = p; dl[i] = now + {16'd0, p};
            add_exp(mk(ST_OK, i[3:0], 0, 0, 1));
          end
        if (!found) add_exp(mk(ST_FULL, 0, 0, 0, 1));
      end
      ACT_CANCEL, ACT_REFRESH: begin
        if (!act[id]) add_exp(mk(ST_INACTIVE, id, 0, 0, 1));
        else begin
          if (a == ACT_CANCEL) act[id] = 0;
          else dl[id] = now + {16'd0, per[id]};
          add_exp(mk(ST_OK, id, 0, 0, 1));
        end
      end
      ACT_RESET: begin
        if (p == per[id] && !fn) add_exp(mk(ST_OK, id, 0, 0, 1));
        else if (!act[id]) add_exp(mk(ST_INACTIVE, id, 0, 0, 1));
        else begin
          start = fn ? now : dl[id] - {16'd0, per[id]};
          per[id] = p; dl[id] = start + {16'd0, p};
          add_exp(mk(ST_OK, id, 0, 0, 1));
        end
      end
      ACT_TICK: tick_table(now);
      ACT_QUERY: begin
        best = -1;
        for (int i = 0; i < SLOTS; i++)
          if (act[i] && (best < 0 || dl[i] < dl[best])) best = i;
        if (best < 0) w = {16'd0, idle_wait};
        else if (now >= dl[best]) w = 0;
        else w = dl[best] - now;
        add_exp(mk(ST_OK, 0, 0, w, 1));
      end
      default: add_exp(mk(ST_OK, 0, 0, 0, 1));
    endcase
  endtask

  always @(posedge clk) begin
    timer_result_t got, exp_r;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        act[i] = 0; rec[i] = 0; per[i] = 0; dl[i] = 0;
      end
      prev_time = 0; idle_wait = IDLE_WAIT_RST; roll_window = ROLLOVER_RST;
      expected_q.delete();
      fail_count <= 0; results_seen <= 0; expiries_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IDLE_WAIT) idle_wait = cfg_data;
        else if (cfg_index == CFG_ROLLOVER) roll_window = cfg_data;
      end
      // output beat compared before the input beat of the same edge is predicted
      if (m_tvalid && m_tready) begin
        got = mk(m_tdata[1:0], m_tdata[5:2], m_tdata[6], m_tdata[54:7], m_tlast);
        results_seen <= results_seen + 1;
        if (got.expired) expiries_seen <= expiries_seen + 1;
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected beat %h last %b", m_tdata, m_tlast);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got != exp_r) begin
            if (fail_count < 10)
              $display("mismatch: exp st %0d id %0d ex %b w %0d l %b / %s %0d %s %0d %s",
                       exp_r.status, exp_r.id, exp_r.expired, exp_r.wait_ms, exp_r.last,
                       "got st", got.status, "id", got.id,
                       $sformatf("ex %b w %0d l %b", got.expired, got.wait_ms, got.last));
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata);
    end
  end

endmodule

/* sim/tb.sv */
// Testbench top: drives items and register writes, judges the run.
`timescale 1ns / 100ps
module tb;
  import dtt_pkg::*;

  logic        clk = 0, rst = 1;
  logic        s_tvalid = 0, s_tready;
  logic [87:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        cfg_valid = 0, cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        m_tvalid, m_tready = 0;
  logic [55:0] m_tdata;
  logic        m_tlast;
  int fail_count, pending_results, results_seen, expiries_seen;
  int send_idle = 0, recv_stall = 0, hold_off = 0, quiet = 0, items_sent = 0;
  logic [47:0] clock_ms = 48'd5000;
  logic [15:0] used_ids = '0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  deadline_timer_table_unit dut (.*);
  dtt_checker chk (.*);

  // receiver: random stall, or a long hold-off counted here
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else m_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // tvalid stays up between back-to-back beats; idle gaps and drain() drop it
  task automatic send(input logic [2:0] a, input logic [3:0] id, input logic [31:0] p,
                      input logic r, input logic fn, input logic [47:0] now);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    s_tvalid <= 1; s_tuser <= a;
    s_tdata <= {2'b00, now, fn, r, p, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending_results != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // reset with from_now 0 on a never-written slot is avoided
  task automatic random_item();
    logic [2:0]  a;
    logic [3:0]  id;
    logic [31:0] p;
    logic        fn;
    a = $urandom_range(99) < 30 ? ACT_ADD : $urandom_range(99) < 4 ? 3'($urandom_range(6, 7))
                                                                   : 3'($urandom_range(1, 5));
    id = 4'($urandom_range(15));
    p = $urandom_range(3) == 0 ? $urandom : $urandom_range(2000);
    fn = 1'($urandom_range(1));
    if (a == ACT_RESET && !used_ids[id]) fn = 1;
    if ($urandom_range(19) == 0) clock_ms = clock_ms - $urandom_range(5000000);
    else clock_ms = clock_ms + $urandom_range(1500);
    if ($urandom_range(29) == 0) clock_ms = 48'({$urandom, $urandom});
    send(a, id, p, 1'($urandom_range(1)), fn, clock_ms);
    if (a == ACT_ADD) used_ids = '1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: idle query, empty tick, inactive ops, unknown action
    send(ACT_QUERY, 0, 0, 0, 0, 48'd100);
    send(ACT_TICK, 0, 0, 0, 0, 48'd100);
    send(ACT_CANCEL, 4'd15, 0, 0, 0, 48'd100);
    send(ACT_REFRESH, 4'd3, 0, 0, 0, 48'd100);
    send(3'd7, 4'd9, 32'hFFFF_FFFF, 1, 1, 48'hFFFF_FFFF_FFFF);
    for (int i = 0; i < 17; i++)
      send(ACT_ADD, 0, (i == 0) ? 32'hFFFF_FFFF : 32'(i * 10), i[0], 0, 48'hFFFF_FFFF_FF00);
    used_ids = '1;
    send(ACT_RESET, 4'd2, 32'd20, 0, 0, 48'd0);
    send(ACT_RESET, 4'd3, 32'd7, 0, 0, 48'd0);
    send(ACT_RESET, 4'd4, 32'd9, 0, 1, 48'd5);
    send(ACT_QUERY, 0, 0, 0, 0, 48'hFFFF_FFFF_FF05);
    send(ACT_TICK, 0, 0, 0, 0, 48'd10);
    drain();
    write_reg(CFG_IDLE_WAIT, 32'hFFFF_FFFF);
    write_reg(CFG_ROLLOVER, 32'd0);
    send(ACT_TICK, 0, 0, 0, 0, 48'd3);
    drain();
    // pressure: long hold-off while items keep coming
    hold_off = 300;
    for (int i = 0; i < 8; i++) send(ACT_ADD, 0, 32'd5, 1, 0, 48'd100);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 26 : 61) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 26 : 61) : 0;
      for (int i = 0; i < 18; i++) random_item();
      drain();
      write_reg(CFG_IDLE_WAIT, (ph == 1) ? 32'd0 : $urandom);
      write_reg(CFG_ROLLOVER, (ph == 2) ? 32'hFFFF_FFFF : $urandom_range(10000000));
    end
    send(ACT_QUERY, 0, 0, 0, 0, clock_ms);
    drain();
    $display("covered %0d items, %0d results, %0d expiries, four idle mixes and a long stall",
             items_sent, results_seen, expiries_seen);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
